// File: rtl/dijkstra_shortest_paths_unit_defines.svh
// Assertion macros shared by the shortest path unit RTL.
`ifndef DIJKSTRA_SHORTEST_PATHS_UNIT_DEFINES_SVH
`define DIJKSTRA_SHORTEST_PATHS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define DSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define DSP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DSP_ASSERT(label, prop, msg)
`define DSP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: rtl/dsp_pkg.sv
// Types and constants shared by the shortest path unit.
package dsp_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_WEIGHT_BITS  = 16;
    localparam int DIST_BITS        = 22;
    localparam int VTX_BITS         = 6;
    localparam int LINK_VTX_BITS    = 8;
    localparam int COUNT_BITS       = 7;
    localparam int PADDR_BITS       = 3;

    localparam logic [DIST_BITS-1:0]  DIST_MAX     = 22'h3FFFFF;
    localparam logic [PADDR_BITS-1:0] ADDR_VCOUNT  = 3'd0;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_EXISTS  = 2'd2;

    typedef struct packed {
        logic                mode;
        logic [VTX_BITS-1:0] first_vertex;
        logic [VTX_BITS-1:0] second_vertex;
        logic [15:0]         weight;
    } in_word_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [VTX_BITS-1:0]  vertex;
        logic [DIST_BITS-1:0] distance;
        logic [VTX_BITS-1:0]  predecessor;
        logic                 has_predecessor;
        logic                 reachable;
        logic                 last;
    } out_word_t;

    // Kinds of word that travel down the cell chain.
    typedef enum logic [2:0] {
        LK_NOP    = 3'd0,
        LK_INIT   = 3'd1,
        LK_VISIT  = 3'd2,
        LK_EDGE   = 3'd3,
        LK_SELECT = 3'd4,
        LK_REPORT = 3'd5
    } link_kind_t;

    typedef struct packed {
        link_kind_t               kind;
        logic [LINK_VTX_BITS-1:0] tag;
        logic [DIST_BITS-1:0]     span;
        logic [LINK_VTX_BITS-1:0] node;
        logic                     hit;
        logic                     mark;
        logic                     last;
    } link_t;

endpackage

// File: rtl/dsp_ram.sv
// Generic single-port RAM with registered read.
module dsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dsp_cell.sv
// One vertex cell of the chain: holds distance, predecessor and marks.
module dsp_cell
    import dsp_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  link_t link_in,
    output link_t link_out
);

    link_t                    link_reg, link_next;
    logic                     visited_reg, visited_next;
    logic                     reached_reg, reached_next;
    logic                     hp_reg, hp_next;
    logic [DIST_BITS-1:0]     dist_reg, dist_next;
    logic [LINK_VTX_BITS-1:0] pred_reg, pred_next;
    logic                     is_me;

    assign is_me = (link_in.tag == LINK_VTX_BITS'(CELL_ID));

    always_comb
    begin
        link_next    = link_in;
        visited_next = visited_reg;
        reached_next = reached_reg;
        hp_next      = hp_reg;
        dist_next    = dist_reg;
        pred_next    = pred_reg;
        case (link_in.kind)
            LK_INIT:
            begin
                visited_next = 1'b0;
                reached_next = is_me;
                hp_next      = 1'b0;
                dist_next    = '0;
            end
            LK_VISIT:
            begin
                if (is_me)
                begin
                    visited_next = 1'b1;
                end
            end
            LK_EDGE:
            begin
                // relax only on a strictly shorter path
                if (is_me && link_in.hit && !visited_reg &&
                    (!reached_reg || link_in.span < dist_reg))
                begin
                    dist_next    = link_in.span;
                    pred_next    = link_in.node;
                    hp_next      = 1'b1;
                    reached_next = 1'b1;
                end
            end
            LK_SELECT:
            begin
                // strict compare keeps the lowest index on ties
                if (!visited_reg && reached_reg && (!link_in.hit || dist_reg < link_in.span))
                begin
                    link_next.hit  = 1'b1;
                    link_next.span = dist_reg;
                    link_next.node = LINK_VTX_BITS'(CELL_ID);
                end
            end
            LK_REPORT:
            begin
                if (is_me)
                begin
                    link_next.span = reached_reg ? dist_reg : '0;
                    link_next.node = hp_reg ? pred_reg : '0;
                    link_next.hit  = reached_reg;
                    link_next.mark = hp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else if (adv)
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            visited_reg <= visited_next;
            reached_reg <= reached_next;
            hp_reg      <= hp_next;
            dist_reg    <= dist_next;
            pred_reg    <= pred_next;
        end
    end

    assign link_out = link_reg;

endmodule

// File: rtl/dijkstra_shortest_paths_unit.sv
// Top level of the shortest path unit: controller, edge memory and cell chain.
//
// Keeps an undirected weighted adjacency matrix in a single-port RAM of
// MAX_VERTICES*MAX_VERTICES words and answers two kinds of input word. An
// add-edge word with a missing endpoint goes straight to its result; else the
// block reads the matrix entry and, unless the edge already exists, writes
// both directions, and then places its single result. A run word drives a
// chain of MAX_VERTICES cells, one per vertex, that pass a word to their
// neighbor every cycle unless the chain is held for the output slot; each
// round of the search streams the picked vertex's matrix row (one RAM read
// per cycle) into the chain, followed by a selection word that collects the
// closest unvisited vertex as it crosses all cells. A run then gives one
// result per vertex in index order. After reset the block sweeps the whole
// matrix to "no edge", one word per cycle, and takes no input word
// meanwhile; write the vertex count register through the APB port at
// address 0 only while no word is in flight.
`include "dijkstra_shortest_paths_unit_defines.svh"

module dijkstra_shortest_paths_unit
    import dsp_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = WEIGHT_BITS + 1;
    localparam int SUM_W = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

    typedef enum logic [12:0] {
        ST_CLEAR      = 13'b0000000000001,
        ST_IDLE       = 13'b0000000000010,
        ST_ADD_CHK    = 13'b0000000000100,
        ST_ADD_WR2    = 13'b0000000001000,
        ST_RESP       = 13'b0000000010000,
        ST_RUN_INIT   = 13'b0000000100000,
        ST_RUN_SEL    = 13'b0000001000000,
        ST_RUN_WAIT   = 13'b0000010000000,
        ST_RUN_EDGES  = 13'b0000100000000,
        ST_RUN_LAST   = 13'b0001000000000,
        ST_RUN_REPORT = 13'b0010000000000,
        ST_RUN_DRAIN  = 13'b0100000000000,
        ST_SPARE      = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_BITS-1:0]  vcount_reg;
    logic [CNT_W-1:0]       n_active;
    logic [AW-1:0]          clr_reg;
    logic [VW-1:0]          a_reg, b_reg, u_reg, cnt_reg, rd_idx_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [1:0]             status_reg;
    logic [DIST_BITS-1:0]   du_reg;
    logic                   rd_pend_reg;
    logic                   out_valid_reg;
    out_word_t              out_reg;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [EW-1:0]          ram_wdata, ram_rdata;
    logic [SUM_W-1:0]       sum;
    logic [DIST_BITS-1:0]   cand;
    logic                   a_ok, ab_ok, last_cnt, adv, slot_free, load_out;
    link_t                  inject;
    link_t                  links [MAX_VERTICES];
    link_t                  chain_end;

    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] r, input logic [VW-1:0] c);
        return AW'(r) * AW'(MAX_VERTICES) + AW'(c);
    endfunction

    // Clamp the vertex count to the matrix size.
    assign n_active = (32'(vcount_reg) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                            : CNT_W'(vcount_reg);
    assign a_ok     = 32'(in_data.first_vertex) < 32'(n_active);
    assign ab_ok    = a_ok && (32'(in_data.second_vertex) < 32'(n_active));
    assign last_cnt = (32'(cnt_reg) == 32'(n_active) - 32'd1);

    // Saturating path length for the row word coming out of the RAM.
    assign sum  = SUM_W'(du_reg) + SUM_W'(ram_rdata[WEIGHT_BITS-1:0]);
    assign cand = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];

    assign chain_end = links[MAX_VERTICES-1];
    // Hold the whole chain while a finished report word waits for the output slot.
    assign adv       = !(chain_end.kind == LK_REPORT && out_valid_reg && !out_ready);
    assign slot_free = !out_valid_reg || out_ready;
    assign load_out  = (state_reg == ST_RESP && slot_free) ||
                       (chain_end.kind == LK_REPORT && adv);

    always_comb
    begin
        state_next = state_reg;
        inject     = '0;
        ram_we     = 1'b0;
        ram_addr   = '0;
        ram_wdata  = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_addr = addr_of(VW'(in_data.first_vertex), VW'(in_data.second_vertex));
                if (in_valid)
                begin
                    if (!in_data.mode)
                    begin
                        state_next = ab_ok ? ST_ADD_CHK : ST_RESP;
                    end
                    else
                    begin
                        state_next = a_ok ? ST_RUN_INIT : ST_RESP;
                    end
                end
            end
            ST_ADD_CHK:
            begin
                if (ram_rdata[WEIGHT_BITS])
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_addr   = addr_of(a_reg, b_reg);
                    ram_wdata  = {1'b1, w_reg};
                    state_next = ST_ADD_WR2;
                end
            end
            ST_ADD_WR2:
            begin
                ram_we     = 1'b1;
                ram_addr   = addr_of(b_reg, a_reg);
                ram_wdata  = {1'b1, w_reg};
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN_INIT:
            begin
                inject.kind = LK_INIT;
                inject.tag  = LINK_VTX_BITS'(a_reg);
                state_next  = ST_RUN_SEL;
            end
            ST_RUN_SEL:
            begin
                inject.kind = LK_SELECT;
                state_next  = ST_RUN_WAIT;
            end
            ST_RUN_WAIT:
            begin
                if (chain_end.kind == LK_SELECT)
                begin
                    if (chain_end.hit)
                    begin
                        inject.kind = LK_VISIT;
                        inject.tag  = chain_end.node;
                        state_next  = ST_RUN_EDGES;
                    end
                    else
                    begin
                        state_next = ST_RUN_REPORT;
                    end
                end
            end
            ST_RUN_EDGES:
            begin
                ram_addr = addr_of(u_reg, cnt_reg);
                if (rd_pend_reg)
                begin
                    inject.kind = LK_EDGE;
                    inject.tag  = LINK_VTX_BITS'(rd_idx_reg);
                    inject.span = cand;
                    inject.node = LINK_VTX_BITS'(u_reg);
                    inject.hit  = ram_rdata[WEIGHT_BITS];
                end
                if (last_cnt)
                begin
                    state_next = ST_RUN_LAST;
                end
            end
            ST_RUN_LAST:
            begin
                inject.kind = LK_EDGE;
                inject.tag  = LINK_VTX_BITS'(rd_idx_reg);
                inject.span = cand;
                inject.node = LINK_VTX_BITS'(u_reg);
                inject.hit  = ram_rdata[WEIGHT_BITS];
                state_next  = ST_RUN_SEL;
            end
            ST_RUN_REPORT:
            begin
                if (adv)
                begin
                    inject.kind = LK_REPORT;
                    inject.tag  = LINK_VTX_BITS'(cnt_reg);
                    inject.last = last_cnt;
                    if (last_cnt)
                    begin
                        state_next = ST_RUN_DRAIN;
                    end
                end
            end
            ST_RUN_DRAIN:
            begin
                if (chain_end.kind == LK_REPORT && chain_end.last && adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_RUN_EDGES);
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (psel && penable && pwrite && paddr == ADDR_VCOUNT)
            begin
                vcount_reg <= pwdata[COUNT_BITS-1:0];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload, search registers and output word.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg;
        if (state_reg == ST_IDLE && in_valid)
        begin
            a_reg      <= VW'(in_data.first_vertex);
            b_reg      <= VW'(in_data.second_vertex);
            w_reg      <= WEIGHT_BITS'(in_data.weight);
            status_reg <= (in_data.mode ? a_ok : ab_ok) ? STAT_OK : STAT_MISSING;
        end
        if (state_reg == ST_ADD_CHK && ram_rdata[WEIGHT_BITS])
        begin
            status_reg <= STAT_EXISTS;
        end
        if (state_reg == ST_RUN_WAIT && chain_end.kind == LK_SELECT)
        begin
            u_reg   <= VW'(chain_end.node);
            du_reg  <= chain_end.span;
            cnt_reg <= '0;
        end
        if (state_reg == ST_RUN_EDGES || (state_reg == ST_RUN_REPORT && adv))
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (load_out)
        begin
            if (state_reg == ST_RESP)
            begin
                out_reg.status          <= status_reg;
                out_reg.vertex          <= '0;
                out_reg.distance        <= '0;
                out_reg.predecessor     <= '0;
                out_reg.has_predecessor <= 1'b0;
                out_reg.reachable       <= 1'b0;
                out_reg.last            <= 1'b1;
            end
            else
            begin
                out_reg.status          <= STAT_OK;
                out_reg.vertex          <= chain_end.tag[VTX_BITS-1:0];
                out_reg.distance        <= chain_end.span;
                out_reg.predecessor     <= chain_end.node[VTX_BITS-1:0];
                out_reg.has_predecessor <= chain_end.mark;
                out_reg.reachable       <= chain_end.hit;
                out_reg.last            <= chain_end.last;
            end
        end
    end

    dsp_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // One cell per vertex; words enter at cell 0 and leave at the far end.
    for (genvar g = 0; g < MAX_VERTICES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            dsp_cell #(
                .CELL_ID (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .link_in  (inject),
                .link_out (links[g])
            );
        end
        else
        begin : g_body
            dsp_cell #(
                .CELL_ID (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .link_in  (links[g-1]),
                .link_out (links[g])
            );
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_VCOUNT) ? 32'(vcount_reg) : 32'd0;

    `DSP_ASSERT_NEVER(a_no_out_in_clear, state_reg == ST_CLEAR && out_valid_reg, "word during clearing pass")
    `DSP_ASSERT(a_ram_write_states, ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_ADD_CHK || state_reg == ST_ADD_WR2), "matrix written outside clear or add")
    `DSP_ASSERT(a_accept_leaves_idle, in_valid && in_ready |=> state_reg != ST_IDLE, "accepted word left no work")

endmodule

// File: test/dsp_path_checker.sv
// Checker for the shortest path unit: predicts result words and compares them.
`timescale 1ns / 1ps

module dsp_path_checker
    import dsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_word_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_word_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    fail_count,
    output int                    pending,
    output int                    checked_count,
    output int                    search_count
);

    localparam int NV = DEF_MAX_VERTICES;

    bit          link_set [NV*NV];
    logic [15:0] link_cost [NV*NV];
    logic [6:0]  vcount;
    out_word_t   expected_words[$];

    assign pending = expected_words.size();

    function automatic out_word_t status_word(logic [1:0] st);
        out_word_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void predict_edge(in_word_t w, int n);
        int a;
        int b;
        a = w.first_vertex;
        b = w.second_vertex;
        if (a >= n || b >= n)
            expected_words.push_back(status_word(STAT_MISSING));
        else if (link_set[a*NV+b])
            expected_words.push_back(status_word(STAT_EXISTS));
        else
        begin
            link_set[a*NV+b] = 1'b1;
            link_set[b*NV+a] = 1'b1;
            link_cost[a*NV+b] = w.weight;
            link_cost[b*NV+a] = w.weight;
            expected_words.push_back(status_word(STAT_OK));
        end
    endfunction

    function automatic void predict_search(int src, int n);
        int        path_len [NV];
        bit        done [NV];
        bit        via [NV];
        int        from [NV];
        int        u;
        int        cand;
        bit        found;
        out_word_t r;
        for (int i = 0; i < NV; i++)
        begin
            path_len[i] = 0;
            done[i] = 0;
            via[i] = 0;
            from[i] = 0;
        end
        for (int iter = 0; iter < n; iter++)
        begin
            found = 0;
            u = 0;
            // pick the closest reached vertex; lowest index wins a tie
            for (int i = 0; i < n; i++)
                if (!done[i] && (i == src || via[i]) && (!found || path_len[i] < path_len[u]))
                begin
                    found = 1;
                    u = i;
                end
            if (!found)
                break;
            done[u] = 1;
            for (int j = 0; j < n; j++)
            begin
                if (done[j] || !link_set[u*NV+j])
                    continue;
                cand = path_len[u] + int'(link_cost[u*NV+j]);
                if (cand > int'(DIST_MAX))
                    cand = int'(DIST_MAX);
                if (!(j == src || via[j]) || cand < path_len[j])
                begin
                    path_len[j] = cand;
                    via[j] = 1;
                    from[j] = u;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r = '0;
            r.status = STAT_OK;
            r.vertex = i[VTX_BITS-1:0];
            r.reachable = (i == src) || via[i];
            r.distance = r.reachable ? path_len[i][DIST_BITS-1:0] : '0;
            r.has_predecessor = via[i];
            r.predecessor = via[i] ? from[i][VTX_BITS-1:0] : '0;
            r.last = (i + 1 == n);
            expected_words.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int        n;
        out_word_t exp_w;
        if (!rst_n)
        begin
            for (int i = 0; i < NV*NV; i++)
            begin
                link_set[i] = 1'b0;
                link_cost[i] = '0;
            end
            vcount = '0;
            fail_count = 0;
            checked_count = 0;
            search_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_VCOUNT)
                vcount = pwdata[COUNT_BITS-1:0];
            n = (vcount > NV) ? NV : int'(vcount);
            if (in_valid && in_ready)
            begin
                if (!in_data.mode)
                    predict_edge(in_data, n);
                else if (int'(in_data.first_vertex) >= n)
                    expected_words.push_back(status_word(STAT_MISSING));
                else
                begin
                    search_count++;
                    predict_search(in_data.first_vertex, n);
                end
            end
            if (out_valid && out_ready)
            begin
                checked_count++;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_data.status !== exp_w.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.vertex !== exp_w.vertex)
                    begin
                        $error("vertex: expected %0d, got %0d", exp_w.vertex, out_data.vertex);
                        fail_count++;
                    end
                    if (out_data.distance !== exp_w.distance)
                    begin
                        $error("distance: expected %0d, got %0d",
                               exp_w.distance, out_data.distance);
                        fail_count++;
                    end
                    if (out_data.predecessor !== exp_w.predecessor)
                    begin
                        $error("predecessor: expected %0d, got %0d",
                               exp_w.predecessor, out_data.predecessor);
                        fail_count++;
                    end
                    if (out_data.has_predecessor !== exp_w.has_predecessor)
                    begin
                        $error("has_predecessor: expected %0d, got %0d",
                               exp_w.has_predecessor, out_data.has_predecessor);
                        fail_count++;
                    end
                    if (out_data.reachable !== exp_w.reachable)
                    begin
                        $error("reachable: expected %0d, got %0d",
                               exp_w.reachable, out_data.reachable);
                        fail_count++;
                    end
                    if (out_data.last !== exp_w.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_w.last, out_data.last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: test/tb_dijkstra_shortest_paths_unit.sv
// Testbench top for the shortest path unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_dijkstra_shortest_paths_unit;
    import dsp_pkg::*;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_RUN = 1'b1;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_word_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked_count;
    int search_count;

    // idle percentages for each side, and a request for a long receiver stall
    int send_idle_pct;
    int recv_idle_pct;
    bit stall_req;
    int sent_count;
    int cur_count;

    dijkstra_shortest_paths_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dsp_path_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked_count(checked_count),
        .search_count (search_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit: far beyond the slowest legal run, including the clearing sweep.
    initial
    begin
        #100ms;
        $display("status: fail");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold-off when asked for.
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req && hold == 0)
                hold = 400;
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    stall_req = 1'b0;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one word; hold it steady until the handshake takes it.
    task automatic send_word(logic mode, int a, int b, int w);
        in_word_t word;
        word.mode = mode;
        word.first_vertex = a[VTX_BITS-1:0];
        word.second_vertex = b[VTX_BITS-1:0];
        word.weight = w[15:0];
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= word;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    // Drop valid and wait for every expected word, then let the pipe settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_VCOUNT;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_count = (value > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : value;
    endtask

    // Pick an endpoint: mostly inside the active count, sometimes anywhere.
    function automatic int pick_vertex();
        if (cur_count == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, cur_count - 1);
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 65535);
            1: return 65535 - $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    initial
    begin
        int phase_counts[15];
        int items;
        int run_pct;
        phase_counts = '{3, 8, 2, 16, 5, 64, 1, 12, 127, 10, 6, 0, 20, 7, 9};
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_req = 1'b0;
        sent_count = 0;
        cur_count = 0;
        send_idle_pct = 22;
        recv_idle_pct = 48;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty graph first; both kinds of word must report a missing vertex.
        send_word(MODE_RUN, 0, 63, 65535);
        send_word(MODE_ADD, 0, 0, 1);
        drain();
        write_count(4);
        send_word(MODE_ADD, 0, 1, 0);
        send_word(MODE_ADD, 1, 0, 5);         // reverse entry already set
        send_word(MODE_ADD, 1, 2, 65535);
        send_word(MODE_ADD, 2, 2, 7);         // self loop never shortens anything
        send_word(MODE_ADD, 0, 2, 65535);     // tie with the path through 1: keep old
        send_word(MODE_ADD, 3, 4, 9);         // endpoint equal to the count
        send_word(MODE_ADD, 63, 0, 9);
        send_word(MODE_ADD, 0, 63, 9);
        send_word(MODE_RUN, 0, 0, 0);
        send_word(MODE_RUN, 3, 63, 65535);    // isolated source, others unreached
        send_word(MODE_RUN, 2, 21, 43690);
        send_word(MODE_RUN, 4, 0, 0);         // source at the count
        send_word(MODE_RUN, 63, 0, 0);
        drain();
        write_count(2);                       // shrink: stored edges stay behind
        send_word(MODE_RUN, 1, 0, 0);
        send_word(MODE_ADD, 1, 2, 3);
        drain();
        write_count(4);                       // grow back: edge 1-2 counts again
        send_word(MODE_RUN, 2, 0, 0);
        send_word(MODE_ADD, 42, 21, 21845);
        drain();

        // Random phases over several counts; each phase ends with the sender paused.
        for (int p = 0; p < 15; p++)
        begin
            if (p < 5)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 48;
            end
            else if (p < 10)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_count(phase_counts[p]);
            // big graphs make each search slow, so run them rarely there
            run_pct = (cur_count >= 32) ? 8 : 22;
            items = (cur_count >= 32) ? 40 : 22;
            if (p == 3)
                stall_req = 1'b1;             // block fills while the sender keeps offering
            for (int k = 0; k < items; k++)
            begin
                if ($urandom_range(0, 99) < run_pct)
                    send_word(MODE_RUN, pick_vertex(), $urandom_range(0, 63),
                              $urandom_range(0, 65535));
                else
                    send_word(MODE_ADD, pick_vertex(), pick_vertex(), pick_weight());
            end
            drain();
        end

        $display("sent %0d words, %0d searches, %0d result words checked",
                 sent_count, search_count, checked_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
